// ===== hdl/deq_pkg.sv =====
package deq_pkg;

    // Number of entries held by the deque
    localparam int DEPTH = 8;
    // Width of the entry count, wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Operation codes carried on func
    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_REAR  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_REAR   = 3'd3,
        FN_PEEK_FRONT = 3'd4,
        FN_PEEK_REAR  = 3'd5
    } deq_func_t;

    // Status codes reported with every result
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } deq_status_t;

    // Shift commands broadcast to every cell; at most one is set per cycle
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } deq_cmd_t;

endpackage

// ===== hdl/deq_cell.sv =====
module deq_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  deq_pkg::deq_cmd_t               cmd,
    input  logic [deq_pkg::DATA_W-1:0]      value,
    input  logic [deq_pkg::DATA_W-1:0]      left_data,
    input  logic                            left_valid,
    input  logic [deq_pkg::DATA_W-1:0]      right_data,
    input  logic                            right_valid,
    output logic [deq_pkg::DATA_W-1:0]      data_q,
    output logic                            valid_q
);
    import deq_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;

    // Work out this cell's next contents from its neighbours
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.push_front)
        begin
            // advance toward the rear
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (cmd.push_rear)
        begin
            // take the new item in the first free cell
            if (!valid_reg && left_valid)
            begin
                data_next  = value;
                valid_next = 1'b1;
            end
        end
        else if (cmd.pop_front)
        begin
            // advance toward the front
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (cmd.pop_rear)
        begin
            // drop the rear entry
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Hold occupancy under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the entry word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_q  = data_reg;
    assign valid_q = valid_reg;

endmodule

// ===== hdl/double_ended_queue.sv =====
// Deque built as a row of cells; the front entry sits in the first cell.
// Result strobed on done in the cycle after start is taken.
// Throughput: one operation per cycle; every operation completes in a single
// update of the cell row, so busy stays low and the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) empties the deque and clears done.
module double_ended_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         func,
    input  logic signed [deq_pkg::DATA_W-1:0]  value,
    output logic                               done,
    output logic signed [deq_pkg::DATA_W-1:0]  data,
    output logic [1:0]                         status,
    output logic                               is_full,
    output logic                               is_empty,
    output logic [3:0]                         count
);
    import deq_pkg::*;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]  cell_valid;
    logic [DEPTH-1:0]  rear_sel;
    logic [DATA_W-1:0] rear_data;
    logic              accept;
    logic              full;
    logic              empty;
    deq_cmd_t          cmd;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    deq_status_t       status_reg;
    deq_status_t       status_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // Build the cell row and link each cell to its neighbours
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] l_data;
        logic              l_valid;
        logic [DATA_W-1:0] r_data;
        logic              r_valid;

        if (i == 0)
        begin : g_first
            assign l_data  = value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_inner_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_inner_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        assign rear_sel[i] = cell_valid[i] && !r_valid;

        deq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .value       (value),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data_q      (cell_data[i]),
            .valid_q     (cell_valid[i])
        );
    end

    // Pick the rear entry: exactly one cell marks itself as rear when occupied
    always_comb
    begin
        rear_data = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            rear_data = rear_data | (cell_data[k] & {DATA_W{rear_sel[k]}});
        end
    end

    // Decode the operation into a shift command, result word and new count
    always_comb
    begin
        cmd         = '0;
        data_next   = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        case (func)
            FN_PUSH_FRONT, FN_PUSH_REAR:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.push_front = (func == FN_PUSH_FRONT);
                    cmd.push_rear  = (func == FN_PUSH_REAR);
                    count_next     = count_reg + 1'b1;
                end
            end
            FN_POP_FRONT, FN_POP_REAR:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.pop_front = (func == FN_POP_FRONT);
                    cmd.pop_rear  = (func == FN_POP_REAR);
                    data_next     = (func == FN_POP_FRONT) ? cell_data[0] : rear_data;
                    count_next    = count_reg - 1'b1;
                end
            end
            FN_PEEK_FRONT, FN_PEEK_REAR:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_next = (func == FN_PEEK_FRONT) ? cell_data[0] : rear_data;
                end
            end
            default:
            begin
                // unused selectors leave the state as it is
            end
        endcase

        if (!accept)
        begin
            cmd        = '0;
            count_next = count_reg;
        end
    end

    // Hold count and result strobe under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Capture the result of the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign done     = done_reg;
    assign data     = data_reg;
    assign status   = status_reg;
    assign is_full  = full;
    assign is_empty = empty;
    assign count    = 4'(count_reg);

endmodule

// ===== tb/deque_checker.sv =====
`timescale 1ns / 100ps

module deque_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [2:0]                        func,
    input  logic signed [deq_pkg::DATA_W-1:0] value,
    input  logic                              done,
    input  logic signed [deq_pkg::DATA_W-1:0] data,
    input  logic [1:0]                        status,
    input  logic                              is_full,
    input  logic                              is_empty,
    input  logic [3:0]                        count,
    output int                                fail_count,
    output int                                pending
);
    import deq_pkg::*;

    // What one operation should report
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        deq_status_t              status;
        logic                     full;
        logic                     empty;
        logic [3:0]               count;
    } deq_outcome_t;

    // Own copy of the deque contents and pointers
    logic signed [DATA_W-1:0] slots [DEPTH];
    int unsigned              head_slot;
    int unsigned              tail_slot;
    int unsigned              held;

    deq_outcome_t expected_outcomes [$];

    // Apply one operation to the local deque and work out its report
    task automatic apply_deque_op(input logic [2:0] op, input logic signed [DATA_W-1:0] word,
                                  output deq_outcome_t outcome);
        logic was_full;
        logic was_empty;
        was_full  = (held >= DEPTH);
        was_empty = (held == 0);
        outcome.data   = '0;
        outcome.status = ST_OK;
        case (op)
            FN_PUSH_FRONT, FN_PUSH_REAR:
            begin
                if (was_full)
                begin
                    outcome.status = ST_FULL;
                end
                else if (was_empty)
                begin
                    // first entry always lands in slot zero
                    head_slot = 0;
                    tail_slot = 0;
                    slots[0]  = word;
                    held      = 1;
                end
                else if (op == FN_PUSH_FRONT)
                begin
                    head_slot        = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                    slots[head_slot] = word;
                    held++;
                end
                else
                begin
                    tail_slot        = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
                    slots[tail_slot] = word;
                    held++;
                end
            end
            FN_POP_FRONT, FN_POP_REAR:
            begin
                if (was_empty)
                begin
                    outcome.status = ST_EMPTY;
                end
                else if (op == FN_POP_FRONT)
                begin
                    outcome.data = slots[head_slot];
                    if (held > 1)
                        head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
                    held--;
                end
                else
                begin
                    outcome.data = slots[tail_slot];
                    if (held > 1)
                        tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
                    held--;
                end
            end
            FN_PEEK_FRONT, FN_PEEK_REAR:
            begin
                if (was_empty)
                    outcome.status = ST_EMPTY;
                else
                    outcome.data = (op == FN_PEEK_FRONT) ? slots[head_slot] : slots[tail_slot];
            end
            default:
            begin
                // unused selectors leave everything alone
            end
        endcase
        outcome.full  = (held >= DEPTH);
        outcome.empty = (held == 0);
        outcome.count = 4'(held);
    endtask

    // Count a failure, report only the first few
    task automatic record_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] deque mismatch: %s", $realtime, what);
    endtask

    // Predict on every accepted item, compare every strobed result
    always @(posedge clk or negedge rst_n)
    begin
        deq_outcome_t outcome;
        deq_outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                slots[i] = '0;
            head_slot  = 0;
            tail_slot  = 0;
            held       = 0;
            fail_count = 0;
            expected_outcomes.delete();
        end
        else
        begin
            if (start && !busy)
            begin
                apply_deque_op(func, value, outcome);
                expected_outcomes.push_back(outcome);
            end
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    record_failure($sformatf("result with no item waiting: data=%0d status=%0d",
                                             data, status));
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (data !== want.data || status !== want.status ||
                        is_full !== want.full || is_empty !== want.empty ||
                        count !== want.count)
                        record_failure({
                            $sformatf("expected data=%0d status=%0d full=%0b empty=%0b count=%0d",
                                      want.data, want.status, want.full, want.empty,
                                      want.count),
                            $sformatf(", got data=%0d status=%0d full=%0b empty=%0b count=%0d",
                                      data, status, is_full, is_empty, count)});
                end
            end
        end
        pending = expected_outcomes.size();
    end

endmodule

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 100ps

module tb_double_ended_queue;
    import deq_pkg::*;

    // Selectors the block must ignore
    localparam logic [2:0] FN_SPARE_LO = 3'd6;
    localparam logic [2:0] FN_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 100000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [2:0]               func;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     is_full;
    logic                     is_empty;
    logic [3:0]               count;
    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;

    double_ended_queue u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .value    (value),
        .done     (done),
        .data     (data),
        .status   (status),
        .is_full  (is_full),
        .is_empty (is_empty),
        .count    (count)
    );

    deque_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .value      (value),
        .done       (done),
        .data       (data),
        .status     (status),
        .is_full    (is_full),
        .is_empty   (is_empty),
        .count      (count),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_double_ended_queue failed");
            $finish;
        end
    end

    // Hold off for gap cycles, then offer one item until it is taken
    task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] word,
                             input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        func  <= op;
        value <= word;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Pick an operation; push_pct steers the fill level
    function automatic logic [2:0] pick_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return (r == 0) ? FN_SPARE_LO : FN_SPARE_HI;
        else if (r < 3 + push_pct)
            return $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_REAR;
        else if (r < 3 + push_pct + (97 - push_pct) * 2 / 3)
            return $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_REAR;
        else
            return $urandom_range(0, 1) ? FN_PEEK_FRONT : FN_PEEK_REAR;
    endfunction

    // Mostly random words, sometimes the extremes
    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int sent;
        int burst;
        int push_pct;
        int gap_max;

        rst_n = 1'b0;
        start = 1'b0;
        func  = FN_PUSH_FRONT;
        value = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty deque: pops, peeks and an unused selector
        send_item(FN_PEEK_FRONT, 32'sd77, 0);
        send_item(FN_POP_FRONT, 32'sd5, 1);
        send_item(FN_POP_REAR, '0, 0);
        send_item(FN_PEEK_REAR, '1, 2);
        send_item(FN_SPARE_LO, 32'sd9, 0);
        // fill from both ends with extreme words, wrapping the front index
        send_item(FN_PUSH_REAR, 32'sh7fff_ffff, 0);
        send_item(FN_PUSH_FRONT, 32'sh8000_0000, 0);
        send_item(FN_PUSH_REAR, '0, 3);
        send_item(FN_PUSH_FRONT, '1, 0);
        send_item(FN_PUSH_FRONT, 32'sh5555_5555, 0);
        send_item(FN_PUSH_REAR, 32'shaaaa_aaaa, 1);
        send_item(FN_PUSH_REAR, 32'sd1, 0);
        send_item(FN_PUSH_FRONT, 32'sh1234_5678, 0);
        // full deque: rejected pushes, peeks, unused selector
        send_item(FN_PUSH_FRONT, 32'sd42, 0);
        send_item(FN_PUSH_REAR, 32'sd43, 2);
        send_item(FN_PEEK_FRONT, '0, 0);
        send_item(FN_PEEK_REAR, '0, 0);
        send_item(FN_SPARE_HI, '1, 0);
        // drain from alternating ends down to empty
        for (int i = 0; i < DEPTH; i++)
            send_item((i % 2) ? FN_POP_REAR : FN_POP_FRONT, pick_word(), i % 3);

        // random bursts, each with its own fill bias and gap pattern
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(16, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 70;
                1:       push_pct = 25;
                default: push_pct = 45;
            endcase
            gap_max = $urandom_range(0, 1) ? 15 : 0;
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                send_item(pick_op(push_pct), pick_word(), $urandom_range(0, gap_max));
                sent++;
            end
        end
        @(negedge clk);
        start <= 1'b0;

        // let the last results drain, then a few idle cycles
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_double_ended_queue passed");
        else
            $display("tb_double_ended_queue failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue.sv
tb/deque_checker.sv
tb/tb_double_ended_queue.sv
